### design/lpc_pkg.sv
`timescale 1ns / 1ps

package lpc_pkg;

  localparam int SAMPLE_WIDTH = 12;
  localparam int NUM_LANES    = 5;
  localparam int THRESH_W     = 12;
  localparam int WEIGHT_W     = 10;
  localparam int POS_W        = 11;
  localparam int CMP_W        = (SAMPLE_WIDTH > THRESH_W) ? SAMPLE_WIDTH : THRESH_W;
  localparam int PROD_W       = SAMPLE_WIDTH + 1 + WEIGHT_W;
  localparam int WSUM_W       = PROD_W + 3;
  localparam int TOT_W        = SAMPLE_WIDTH + 3;
  localparam int MAG_W        = WSUM_W;
  localparam int CNT_W        = $clog2(MAG_W);

  localparam logic [THRESH_W-1:0] THRESH_RESET  = 12'd1000;
  localparam logic signed [POS_W-1:0] CENTER_OFFSET = 11'sd163;

  localparam logic signed [WEIGHT_W-1:0] LANE_WEIGHT [NUM_LANES] = '{
    -10'sd390, -10'sd240, -10'sd85, 10'sd70, 10'sd240
  };

  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] sample_0;
    logic [SAMPLE_WIDTH-1:0] sample_1;
    logic [SAMPLE_WIDTH-1:0] sample_2;
    logic [SAMPLE_WIDTH-1:0] sample_3;
    logic [SAMPLE_WIDTH-1:0] sample_4;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] line_pos;
    logic                    line_seen;
  } out_item_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] prod;
    logic [SAMPLE_WIDTH-1:0]  samp;
  } lane_res_t;

  typedef struct packed {
    logic signed [WSUM_W-1:0] wsum;
    logic [TOT_W-1:0]         total;
  } sum_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SUM   = 5'b00010,
    S_CHECK = 5'b00100,
    S_DIV   = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

endpackage

### design/lpc_lane.sv
`timescale 1ns / 1ps

module lpc_lane (
  input  logic                                clk_i,
  input  logic                                load_i,
  input  logic [lpc_pkg::SAMPLE_WIDTH-1:0]    sample_i,
  input  logic [lpc_pkg::THRESH_W-1:0]        thresh_i,
  input  logic signed [lpc_pkg::WEIGHT_W-1:0] weight_i,
  output lpc_pkg::lane_res_t                  res_o
);
  import lpc_pkg::*;

  logic      dark;
  lane_res_t res_d, res_q;

  assign dark = CMP_W'(sample_i) > CMP_W'(thresh_i);

  always_comb begin
    res_d.prod = '0;
    res_d.samp = '0;
    if (dark) begin
      res_d.prod = $signed({1'b0, sample_i}) * weight_i;
      res_d.samp = sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

### design/lpc_merge.sv
`timescale 1ns / 1ps

module lpc_merge (
  input  logic               clk_i,
  input  logic               load_i,
  input  lpc_pkg::lane_res_t lane_i [lpc_pkg::NUM_LANES],
  output lpc_pkg::sum_t      sum_o
);
  import lpc_pkg::*;

  sum_t sum_d, sum_q;

  always_comb begin
    sum_d.wsum  = '0;
    sum_d.total = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      sum_d.wsum  = sum_d.wsum + WSUM_W'(lane_i[i].prod);
      sum_d.total = sum_d.total + TOT_W'(lane_i[i].samp);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

### design/lpc_div.sv
`timescale 1ns / 1ps

module lpc_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [lpc_pkg::WSUM_W-1:0] dividend_i,
  input  logic [lpc_pkg::TOT_W-1:0]         divisor_i,
  output logic                              busy_o,
  output logic signed [lpc_pkg::POS_W-1:0]  quot_o
);
  import lpc_pkg::*;

  logic               busy_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [MAG_W-1:0]   quo_q, quo_d;
  logic [TOT_W-1:0]   rem_q, rem_d;
  logic [TOT_W-1:0]   dsr_q;
  logic               neg_q;
  logic [TOT_W:0]     trial, diff;
  logic [POS_W-1:0]   qmag;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem_q, quo_q[MAG_W-1]};
    diff  = trial - {1'b0, dsr_q};
    quo_d = {quo_q[MAG_W-2:0], 1'b0};
    rem_d = trial[TOT_W-1:0];
    if (trial >= {1'b0, dsr_q}) begin
      rem_d    = diff[TOT_W-1:0];
      quo_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(MAG_W - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[WSUM_W-1];
      quo_q <= dividend_i[WSUM_W-1] ? MAG_W'(-dividend_i) : MAG_W'(dividend_i);
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  // quotient magnitude never exceeds the largest weight magnitude, 390
  assign qmag   = quo_q[POS_W-1:0];
  assign quot_o = neg_q ? -$signed(qmag) : $signed(qmag);
  assign busy_o = busy_q;

endmodule

### design/line_position_centroid.sv
`timescale 1ns / 1ps

// path when a line is seen: lane registers, merge register, check state, serial divider, output register;
// the divider is skipped when no sample is dark
// items are taken one at a time; a seen line passes through the 26-step serial divider
// an item is accepted only while the core is idle; a waiting result sits in the output register
// reset: async active low; threshold returns to 1000, held position to 0, no result pending

module line_position_centroid (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  lpc_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output lpc_pkg::out_item_t             out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lpc_pkg::THRESH_W-1:0]   cfg_data_i
);
  import lpc_pkg::*;

  state_e                  state_q, state_d;
  logic [THRESH_W-1:0]     thresh_q;
  logic signed [POS_W-1:0] held_q;
  logic                    res_seen_q;
  logic                    out_valid_q;
  out_item_t               out_data_q;
  logic                    in_accept, out_free;
  logic                    div_start, div_busy;
  logic signed [POS_W-1:0] div_quot;
  logic [SAMPLE_WIDTH-1:0] samp [NUM_LANES];
  lane_res_t               lane_res [NUM_LANES];
  sum_t                    sum;

  assign samp[0] = in_data_i.sample_0;
  assign samp[1] = in_data_i.sample_1;
  assign samp[2] = in_data_i.sample_2;
  assign samp[3] = in_data_i.sample_3;
  assign samp[4] = in_data_i.sample_4;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  for (genvar g = 0; g < NUM_LANES; g++) begin : gen_lane
    lpc_lane u_lane (
      .clk_i   (clk_i),
      .load_i  (in_accept),
      .sample_i(samp[g]),
      .thresh_i(thresh_q),
      .weight_i(LANE_WEIGHT[g]),
      .res_o   (lane_res[g])
    );
  end

  lpc_merge u_merge (
    .clk_i (clk_i),
    .load_i(state_q == S_SUM),
    .lane_i(lane_res),
    .sum_o (sum)
  );

  assign div_start = (state_q == S_CHECK) && (sum.total != '0);

  lpc_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(sum.wsum),
    .divisor_i (sum.total),
    .busy_o    (div_busy),
    .quot_o    (div_quot)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_accept) state_d = S_SUM;
      S_SUM:   state_d = S_CHECK;
      S_CHECK: state_d = div_start ? S_DIV : S_OUT;
      S_DIV:   if (!div_busy) state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      thresh_q    <= THRESH_RESET;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        thresh_q <= cfg_data_i;
      end
      if (state_q == S_DIV && !div_busy) begin
        held_q <= div_quot + CENTER_OFFSET;
      end
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result staged until the output register frees up
  always_ff @(posedge clk_i) begin
    if (state_q == S_CHECK) begin
      res_seen_q <= div_start;
    end
    if (state_q == S_OUT && out_free) begin
      out_data_q.line_pos  <= held_q;
      out_data_q.line_seen <= res_seen_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### design/lpc_chk.sv
`timescale 1ns / 1ps

module lpc_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input lpc_pkg::out_item_t            out_data_o
);
  import lpc_pkg::*;

  // items accepted but not yet delivered: at most one in the core, one in the output register
  logic [1:0]              pend_q;
  logic signed [POS_W-1:0] last_pos_q;
  logic                    in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= 2'd0;
      last_pos_q <= '0;
    end else begin
      if (in_acc && !out_acc) begin
        pend_q <= pend_q + 2'd1;
      end else if (!in_acc && out_acc) begin
        pend_q <= pend_q - 2'd1;
      end
      if (out_acc && out_data_o.line_seen) begin
        last_pos_q <= out_data_o.line_pos;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output item changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input taken while an item is in flight");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("output item without a pending input item");

  a_held_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.line_seen |-> out_data_o.line_pos == last_pos_q)
    else $error("held position differs from last seen position");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.line_seen |->
      out_data_o.line_pos >= -11'sd227 && out_data_o.line_pos <= 11'sd403)
    else $error("line position out of range");

endmodule

bind line_position_centroid lpc_chk u_lpc_chk (.*);
